[rtl/matrix_multiply_macros.svh]
// Assertion macros shared by the matrix multiply RTL.
// Clock and reset port names are fixed to clock and reset.
`ifndef MATRIX_MULTIPLY_MACROS_SVH
`define MATRIX_MULTIPLY_MACROS_SVH

// checked only outside reset
`define MM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked at every edge, reset included
`define MM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[rtl/mm_pkg.sv]
// Shared constants, types and helpers for the matrix multiply block.
// No dependencies.
package mm_pkg;

   localparam int MAX_DIM   = 8;
   localparam int FRAC_BITS = 16;

   localparam int CFG_W     = 4;
   localparam int POS_W     = 3;
   localparam int CMP_W     = POS_W + 1;
   localparam int REQ_W     = 2;
   localparam int CSR_IDX_W = 2;
   localparam int VAL_W     = 32;
   localparam int PROD_W    = 2 * VAL_W;
   localparam int DIM_W     = $clog2(MAX_DIM + 1);
   localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int ADDR_W    = 2 * IDX_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam int ACC_W     = PROD_W + $clog2(MAX_DIM) + 1;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_A = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_B = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B = 2'd3;

   localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
   localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
   localparam logic [REQ_W-1:0] REQ_START  = 2'd2;

   typedef struct packed {
      logic [REQ_W-1:0]        req_type;
      logic [POS_W-1:0]        row_index;
      logic [POS_W-1:0]        col_index;
      logic signed [VAL_W-1:0] element_value;
   } req_word_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] product_value;
      logic [POS_W-1:0]        out_row;
      logic [POS_W-1:0]        out_col;
      logic                    last_element;
      logic                    size_error;
   } rsp_word_type;

   typedef struct packed {
      logic             first;
      logic             last_k;
      logic             last_el;
      logic             err;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } tag_type;

   typedef struct packed {
      logic              wr_a;
      logic              wr_b;
      logic [ADDR_W-1:0] wr_addr;
      logic              issue;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
      tag_type           tag;
   } dp_cmd_type;

   typedef struct packed {
      logic advance;
   } dp_status_type;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
      logic [DIM_W-1:0] d;
      priority if (v == '0) begin
         d = DIM_W'(1);
      end else if (v > CFG_W'(MAX_DIM)) begin
         d = DIM_W'(MAX_DIM);
      end else begin
         d = DIM_W'(v);
      end
      return d;
   endfunction

endpackage

[rtl/mm_datapath.sv]
// Datapath: A and B stores, multiply-accumulate pipeline, round/saturate, result register.
// Depends on mm_pkg and matrix_multiply_macros.svh.
`include "matrix_multiply_macros.svh"

module mm_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  mm_pkg::dp_cmd_type            cmd,
   input  logic signed [mm_pkg::VAL_W-1:0] wr_value,
   output mm_pkg::dp_status_type         status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mm_pkg::rsp_word_type          rsp_data
);

   localparam logic [mm_pkg::ACC_W-1:0] ROUND_INIT =
      mm_pkg::ACC_W'(mm_pkg::FRAC_BITS > 0) << (mm_pkg::FRAC_BITS > 0 ? mm_pkg::FRAC_BITS - 1 : 0);

   logic signed [mm_pkg::VAL_W-1:0] mem_a [mm_pkg::MEM_DEPTH];
   logic signed [mm_pkg::VAL_W-1:0] mem_b [mm_pkg::MEM_DEPTH];

   logic advance;

   // stage 1: store read
   logic                            v1_ff, v1_in;
   mm_pkg::tag_type                 tag1_ff;
   logic signed [mm_pkg::VAL_W-1:0] rd_a_ff, rd_b_ff;

   // stage 2: product
   logic                             v2_ff, v2_in;
   mm_pkg::tag_type                  tag2_ff;
   logic signed [mm_pkg::PROD_W-1:0] prod_ff, prod_in;

   // stage 3: accumulate
   logic                            v3_ff, v3_in;
   mm_pkg::tag_type                 tag3_ff;
   logic signed [mm_pkg::ACC_W-1:0] acc_ff, acc_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   mm_pkg::rsp_word_type rsp_ff, rsp_in;

   logic signed [mm_pkg::ACC_W-1:0] shifted;
   logic [mm_pkg::ACC_W-mm_pkg::VAL_W:0] hi_bits;
   logic                            fits;
   logic signed [mm_pkg::VAL_W-1:0] sat_value;

   assign advance        = !rsp_valid_ff || rsp_ready;
   assign status.advance = advance;

   always_ff @(posedge clock) begin
      if (cmd.wr_a) begin
         mem_a[cmd.wr_addr] <= wr_value;
      end
      if (cmd.wr_b) begin
         mem_b[cmd.wr_addr] <= wr_value;
      end
      if (advance) begin
         rd_a_ff <= mem_a[cmd.rd_addr_a];
         rd_b_ff <= mem_b[cmd.rd_addr_b];
      end
   end

   always_comb begin
      v1_in   = advance ? cmd.issue : v1_ff;
      v2_in   = advance ? v1_ff : v2_ff;
      v3_in   = advance ? v2_ff : v3_ff;
      prod_in = mm_pkg::PROD_W'(rd_a_ff) * mm_pkg::PROD_W'(rd_b_ff);
      acc_in  = (tag2_ff.first ? $signed(ROUND_INIT) : acc_ff) + mm_pkg::ACC_W'(prod_ff);

      shifted   = acc_ff >>> mm_pkg::FRAC_BITS;
      hi_bits   = shifted[mm_pkg::ACC_W-1:mm_pkg::VAL_W-1];
      fits      = (&hi_bits) || (~|hi_bits);
      sat_value = fits ? shifted[mm_pkg::VAL_W-1:0]
                       : (shifted[mm_pkg::ACC_W-1] ? {1'b1, {(mm_pkg::VAL_W-1){1'b0}}}
                                                   : {1'b0, {(mm_pkg::VAL_W-1){1'b1}}});

      rsp_in.product_value = tag3_ff.err ? '0 : sat_value;
      rsp_in.out_row       = mm_pkg::POS_W'(tag3_ff.row);
      rsp_in.out_col       = mm_pkg::POS_W'(tag3_ff.col);
      rsp_in.last_element  = tag3_ff.last_el;
      rsp_in.size_error    = tag3_ff.err;
      rsp_valid_in         = advance ? (v3_ff && tag3_ff.last_k) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag1_ff <= cmd.tag;
         tag2_ff <= tag1_ff;
         prod_ff <= prod_in;
         tag3_ff <= tag2_ff;
         if (v2_ff) begin
            acc_ff <= acc_in;
         end
         if (v3_ff && tag3_ff.last_k) begin
            rsp_ff <= rsp_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `MM_ASSERT(a_last_reaches_out, (v3_ff && tag3_ff.last_el && advance) |=> (rsp_valid_ff && rsp_ff.last_element), "final element did not reach the result register")
   `MM_ASSERT(a_err_word_clean, (rsp_valid_ff && rsp_ff.size_error) |-> (rsp_ff.product_value == '0 && rsp_ff.last_element), "size error word malformed")
   `MM_ASSERT(a_rsp_hold, (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)), "held word changed")

endmodule

[rtl/mm_ctrl.sv]
// Controller: configuration registers, request decode and the compute sequencer.
// Depends on mm_pkg and matrix_multiply_macros.svh.
`include "matrix_multiply_macros.svh"

module mm_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  mm_pkg::req_word_type            req_data,
   input  logic                            csr_wr_en,
   input  logic [mm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mm_pkg::CFG_W-1:0]        csr_wdata,
   input  mm_pkg::dp_status_type           status,
   output mm_pkg::dp_cmd_type              cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_ERR  = 2'd2;

   logic [1:0] state_ff, state_in;

   logic [mm_pkg::CFG_W-1:0] rows_a_ff, cols_a_ff, rows_b_ff, cols_b_ff;
   logic [mm_pkg::DIM_W-1:0] ra, ca, rb, cb;

   logic [mm_pkg::IDX_W-1:0] row_ff, row_in, col_ff, col_in, inner_ff, inner_in;

   logic accept, is_start, row_last, col_last, inner_last, in_a, in_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= mm_pkg::CFG_RESET;
         cols_a_ff <= mm_pkg::CFG_RESET;
         rows_b_ff <= mm_pkg::CFG_RESET;
         cols_b_ff <= mm_pkg::CFG_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mm_pkg::CSR_ROWS_A: rows_a_ff <= csr_wdata;
            mm_pkg::CSR_COLS_A: cols_a_ff <= csr_wdata;
            mm_pkg::CSR_ROWS_B: rows_b_ff <= csr_wdata;
            mm_pkg::CSR_COLS_B: cols_b_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign ra = mm_pkg::eff_dim(rows_a_ff);
   assign ca = mm_pkg::eff_dim(cols_a_ff);
   assign rb = mm_pkg::eff_dim(rows_b_ff);
   assign cb = mm_pkg::eff_dim(cols_b_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_start  = accept && (req_data.req_type == mm_pkg::REQ_START);

   assign in_a = ({1'b0, req_data.row_index} < mm_pkg::CMP_W'(ra))
              && ({1'b0, req_data.col_index} < mm_pkg::CMP_W'(ca));
   assign in_b = ({1'b0, req_data.row_index} < mm_pkg::CMP_W'(rb))
              && ({1'b0, req_data.col_index} < mm_pkg::CMP_W'(cb));

   assign inner_last = (mm_pkg::DIM_W'(inner_ff) + mm_pkg::DIM_W'(1)) == ca;
   assign col_last   = (mm_pkg::DIM_W'(col_ff) + mm_pkg::DIM_W'(1)) == cb;
   assign row_last   = (mm_pkg::DIM_W'(row_ff) + mm_pkg::DIM_W'(1)) == ra;

   always_comb begin
      cmd.wr_a      = accept && (req_data.req_type == mm_pkg::REQ_LOAD_A) && in_a;
      cmd.wr_b      = accept && (req_data.req_type == mm_pkg::REQ_LOAD_B) && in_b;
      cmd.wr_addr   = {req_data.row_index[mm_pkg::IDX_W-1:0],
                       req_data.col_index[mm_pkg::IDX_W-1:0]};
      cmd.issue     = (state_ff != ST_IDLE);
      cmd.rd_addr_a = {row_ff, inner_ff};
      cmd.rd_addr_b = {inner_ff, col_ff};
      cmd.tag.first = (inner_ff == '0);
      cmd.tag.row   = row_ff;
      cmd.tag.col   = col_ff;
      if (state_ff == ST_ERR) begin
         cmd.tag.last_k  = 1'b1;
         cmd.tag.last_el = 1'b1;
         cmd.tag.err     = 1'b1;
      end else begin
         cmd.tag.last_k  = inner_last;
         cmd.tag.last_el = inner_last && col_last && row_last;
         cmd.tag.err     = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      inner_in = inner_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (is_start) begin
               state_in = (ca != rb) ? ST_ERR : ST_RUN;
            end
         end
         ST_RUN: begin
            if (status.advance) begin
               if (inner_last) begin
                  inner_in = '0;
                  if (col_last) begin
                     col_in = '0;
                     if (row_last) begin
                        row_in   = '0;
                        state_in = ST_IDLE;
                     end else begin
                        row_in = row_ff + mm_pkg::IDX_W'(1);
                     end
                  end else begin
                     col_in = col_ff + mm_pkg::IDX_W'(1);
                  end
               end else begin
                  inner_in = inner_ff + mm_pkg::IDX_W'(1);
               end
            end
         end
         ST_ERR: begin
            if (status.advance) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         inner_ff <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         inner_ff <= inner_in;
      end
   end

   `MM_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE), "controller not idle after reset")
   `MM_ASSERT(a_inner_bound, (state_ff == ST_RUN) |-> (mm_pkg::DIM_W'(inner_ff) < ca), "inner index past cols_a")
   `MM_ASSERT(a_mismatch_err, (is_start && (ca != rb)) |=> (state_ff == ST_ERR), "size mismatch did not raise error")

endmodule

[rtl/matrix_multiply.sv]
// Top level of the dense matrix multiply block.
// Depends on mm_pkg, mm_ctrl and mm_datapath.
//
// Load words (A or B element) are taken one per clock while idle, and configuration
// writes one per clock. A start word runs rows_a * cols_b * cols_a products through
// the single shared 32x32 multiply-accumulate unit, one product per cycle while the
// result register is empty or taken; its sums then pass the multiply, accumulate and
// result register stages after the last store read; new words are taken again once the
// last product has been issued. A size mismatch gives one error word. When the result
// register is not taken the whole compute pipeline holds. Stores are not cleared at
// reset; every element read by a start must have been loaded first.
module matrix_multiply (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  mm_pkg::req_word_type         req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output mm_pkg::rsp_word_type         rsp_data,
   input  logic                         csr_wr_en,
   input  logic [mm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mm_pkg::CFG_W-1:0]     csr_wdata
);

   mm_pkg::dp_cmd_type    cmd;
   mm_pkg::dp_status_type status;

   mm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .cmd       (cmd)
   );

   mm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .wr_value  (req_data.element_value),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
